>>> src/multi_queue_fifo_unit_defines.svh
// Assertion macros shared by the multi-queue FIFO modules.
`ifndef MULTI_QUEUE_FIFO_UNIT_DEFINES_SVH
`define MULTI_QUEUE_FIFO_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MQF_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MQF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/mqf_pkg.sv
// Package with widths, codes and controller/datapath types of the multi-queue FIFO.
package mqf_pkg;

  // Request field widths
  localparam int MODE_W   = 2;
  localparam int QIN_W    = 4;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;

  // Packed stream layouts
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int IN_MODE_LSB  = 0;
  localparam int IN_Q_LSB     = IN_MODE_LSB + MODE_W;
  localparam int IN_VAL_LSB   = IN_Q_LSB + QIN_W;
  localparam int OUT_STAT_LSB = VAL_W;
  localparam int IN_PAD_W  = IN_DATA_W - MODE_W - QIN_W - VAL_W;
  localparam int OUT_PAD_W = OUT_DATA_W - VAL_W - STAT_W;

  // Default geometry
  localparam int DEF_QUEUES = 16;
  localparam int DEF_DEPTH  = 64;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
    logic load_out;
  } mqf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } mqf_sts_t;

endpackage

>>> src/multi_queue_fifo_unit.sv
// Multi-queue FIFO unit: QUEUES independent rings of DEPTH signed 32-bit words in one
// shared store. Each request pushes to, reads the front of, or pops one queue and
// returns exactly one result. A request is first captured while its queue's head and
// count are read from the metadata memory; next the shared element store is accessed
// and the metadata written back; then the output register is loaded once it is free.
// The next request is taken while a result still waits there. After reset a clearing
// pass writes zero head and count to every queue, one per cycle, during which no
// request is accepted.
module multi_queue_fifo_unit
  import mqf_pkg::*;
#(
  parameter int QUEUES = DEF_QUEUES,
  parameter int DEPTH  = DEF_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [1:0] mode, [5:2] queue_index, [37:6] value, [39:38] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [31:0] front_value, [33:32] status, [39:34] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  mqf_cmd_t cmd;
  mqf_sts_t sts;

  mqf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid_i),
    .s_axis_tready (s_axis_tready_o),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  mqf_datapath #(
    .QUEUES (QUEUES),
    .DEPTH  (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata_i),
    .m_axis_tvalid (m_axis_tvalid_o),
    .m_axis_tready (m_axis_tready_i),
    .m_axis_tdata  (m_axis_tdata_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

>>> src/mqf_ctrl.sv
// Controller state machine sequencing clear, accept, execute and result steps.
`include "multi_queue_fifo_unit_defines.svh"

module mqf_ctrl
  import mqf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_axis_tvalid,
  output logic     s_axis_tready,
  input  mqf_sts_t sts_i,
  output mqf_cmd_t cmd_o
);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_EXEC   = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0] state_q, state_d;

  // Decode commands and next state
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    s_axis_tready  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `MQF_ASSERT_NEXT(a_accept_exec, clk_i, rst_ni, cmd_o.accept, state_q == S_EXEC, "accept not followed by execute")
  `MQF_ASSERT_NEXT(a_clear_done, clk_i, rst_ni, (state_q == S_CLEAR) && sts_i.clear_last, state_q == S_IDLE, "clear pass did not end")

endmodule

>>> src/mqf_datapath.sv
// Datapath: queue metadata memory, shared element store and result register.
`include "multi_queue_fifo_unit_defines.svh"

module mqf_datapath
  import mqf_pkg::*;
#(
  parameter int QUEUES = DEF_QUEUES,
  parameter int DEPTH  = DEF_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  mqf_cmd_t              cmd_i,
  output mqf_sts_t              sts_o
);

  localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int QX_W   = ((QIDX_W > QIN_W) ? QIDX_W : QIN_W) + 1;
  localparam int PW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int SW     = PW + 1;
  localparam int MW     = PW + CW;
  localparam int AW     = $clog2(QUEUES * DEPTH);
  localparam logic [QX_W-1:0]   QUEUES_X  = QX_W'(QUEUES);
  localparam logic [QIDX_W-1:0] CLR_LAST  = QIDX_W'(QUEUES - 1);
  localparam logic [CW-1:0]     DEPTH_C   = CW'(DEPTH);
  localparam logic [SW-1:0]     DEPTH_S   = SW'(DEPTH);
  localparam logic [PW-1:0]     HEAD_LAST = PW'(DEPTH - 1);
  localparam logic [AW-1:0]     DEPTH_A   = AW'(DEPTH);

  // Memories: per-queue head/count and shared element ring storage
  logic [MW-1:0]    meta_mem  [QUEUES];
  logic [VAL_W-1:0] store_mem [QUEUES*DEPTH];

  logic [QX_W-1:0]   q_in_x;
  logic [QIDX_W-1:0] clr_cnt_q;
  logic [MODE_W-1:0] mode_q;
  logic [QIDX_W-1:0] qidx_q;
  logic              qvalid_q;
  logic [VAL_W-1:0]  value_q;
  logic [MW-1:0]     meta_rd_q;
  logic [VAL_W-1:0]  store_rd_q;
  logic [STAT_W-1:0] status_q, status_d;
  logic              rd_hit_q;
  logic              out_valid_q;
  logic [VAL_W-1:0]  out_front_q;
  logic [STAT_W-1:0] out_status_q;

  logic [PW-1:0]  head, head_inc;
  logic [CW-1:0]  occ, occ_n;
  logic [SW-1:0]  offset, pos_sum;
  logic [PW-1:0]  pos;
  logic [AW-1:0]  store_addr;
  logic           push_ok, nonempty, read_ok, pop_ok;
  logic           meta_we;
  logic [QIDX_W-1:0] meta_waddr;
  logic [MW-1:0]  meta_wdata;

  assign q_in_x = QX_W'(s_axis_tdata[IN_Q_LSB +: QIN_W]);

  // Capture the request and read its queue's metadata
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q    <= s_axis_tdata[IN_MODE_LSB +: MODE_W];
      qidx_q    <= q_in_x[QIDX_W-1:0];
      qvalid_q  <= (q_in_x < QUEUES_X);
      value_q   <= s_axis_tdata[IN_VAL_LSB +: VAL_W];
      meta_rd_q <= meta_mem[q_in_x[QIDX_W-1:0]];
    end
  end

  // Decode the operation against the queue's head and count
  assign head     = meta_rd_q[MW-1:CW];
  assign occ      = meta_rd_q[CW-1:0];
  assign nonempty = qvalid_q && (occ != '0);
  assign push_ok  = (mode_q == MODE_PUSH) && qvalid_q && (occ != DEPTH_C);
  assign read_ok  = (mode_q == MODE_READ) && nonempty;
  assign pop_ok   = (mode_q == MODE_POP) && nonempty;
  assign head_inc = (head == HEAD_LAST) ? '0 : head + 1'b1;

  // Ring slot: head plus tail offset, wrapped once
  assign offset  = (mode_q == MODE_PUSH) ? SW'(occ) : '0;
  assign pos_sum = SW'(head) + offset;
  always_comb begin
    if (pos_sum >= DEPTH_S) pos = PW'(pos_sum - DEPTH_S);
    else                    pos = pos_sum[PW-1:0];
  end
  assign store_addr = AW'(qidx_q) * DEPTH_A + AW'(pos);

  always_comb begin
    case (mode_q)
      MODE_PUSH: status_d = push_ok ? ST_DONE : ST_FULL;
      MODE_READ: status_d = nonempty ? ST_DONE : ST_EMPTY;
      MODE_POP:  status_d = nonempty ? ST_DONE : ST_EMPTY;
      default:   status_d = ST_DONE;
    endcase
  end

  // Metadata write: clear sweep, or the executed push or pop
  assign occ_n      = push_ok ? occ + 1'b1 : occ - 1'b1;
  assign meta_we    = cmd_i.clear || (cmd_i.exec && (push_ok || pop_ok));
  assign meta_waddr = cmd_i.clear ? clr_cnt_q : qidx_q;
  assign meta_wdata = cmd_i.clear ? '0 : {(pop_ok ? head_inc : head), occ_n};

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
  end

  // Advance the clear counter through all queues after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear && (clr_cnt_q != CLR_LAST)) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Element store: write pushed value, read front word
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push_ok) store_mem[store_addr] <= value_q;
    if (cmd_i.exec && read_ok) store_rd_q <= store_mem[store_addr];
  end

  // Hold the request's status until the result is loaded
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      rd_hit_q <= read_ok;
    end
  end

  // Output register: load a result, drop it when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_front_q  <= rd_hit_q ? store_rd_q : '0;
      out_status_q <= status_q;
    end
  end

  assign m_axis_tvalid    = out_valid_q;
  assign m_axis_tdata     = {{OUT_PAD_W{1'b0}}, out_status_q, out_front_q};
  assign sts_o.clear_last = (clr_cnt_q == CLR_LAST);
  assign sts_o.out_free   = !out_valid_q || m_axis_tready;

  `MQF_ASSERT_SAME(a_load_free, clk_i, rst_ni, cmd_i.load_out, !out_valid_q || m_axis_tready, "result overwritten before taken")
  `MQF_ASSERT_SAME(a_push_room, clk_i, rst_ni, cmd_i.exec && push_ok, occ < DEPTH_C, "push into a full queue")

endmodule

>>> tb/sv/tb_multi_queue_fifo_unit.sv
// Self-checking testbench for the multi-queue FIFO unit: directed table, then random bursts.
`timescale 1ns / 100ps

module tb_multi_queue_fifo_unit;
  import mqf_pkg::*;

  localparam int QUEUES = DEF_QUEUES;
  localparam int DEPTH  = DEF_DEPTH;
  // Unused operation code: no state change, status done
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
  localparam int REQ_TARGET  = 1180;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [VAL_W-1:0]  front;
    logic [STAT_W-1:0] stat;
  } fifo_result_t;

  typedef struct {
    logic [MODE_W-1:0] op;
    logic [QIN_W-1:0]  q;
    logic [VAL_W-1:0]  val;
    int                reps;
    bit                typed;
    logic [VAL_W-1:0]  front;
    logic [STAT_W-1:0] stat;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Shadow state of the queue bank
  logic [5:0]       ring_head [QUEUES];
  logic [6:0]       ring_count[QUEUES];
  logic [VAL_W-1:0] ring_word [QUEUES][DEPTH];

  fifo_result_t pending_results[$];
  dir_row_t     dir_tab[23];

  bit calm;
  int errors;
  int n_push, n_read, n_pop, n_nop;
  int n_full, n_empty, n_results;

  always #1 clk_i = ~clk_i;

  multi_queue_fifo_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  // Apply one request to the shadow state and return the result it should produce
  function automatic fifo_result_t apply_fifo_op(logic [MODE_W-1:0] op, logic [QIN_W-1:0] q,
                                                 logic [VAL_W-1:0] val);
    fifo_result_t r;
    logic [5:0]   slot;
    r.front = '0;
    r.stat  = ST_DONE;
    case (op)
      MODE_PUSH: begin
        if (ring_count[q] >= DEPTH) begin
          r.stat = ST_FULL;
        end else begin
          slot = 6'(ring_head[q] + ring_count[q]);
          ring_word[q][slot] = val;
          ring_count[q] = ring_count[q] + 7'd1;
        end
      end
      MODE_READ: begin
        if (ring_count[q] == 0) r.stat = ST_EMPTY;
        else r.front = ring_word[q][ring_head[q]];
      end
      MODE_POP: begin
        if (ring_count[q] == 0) begin
          r.stat = ST_EMPTY;
        end else begin
          ring_head[q]  = ring_head[q] + 6'd1;
          ring_count[q] = ring_count[q] - 7'd1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Present one request after a random gap, hold it until taken, then record the expectation
  task automatic send_request(input logic [MODE_W-1:0] op, input logic [QIN_W-1:0] q,
                              input logic [VAL_W-1:0] val, input bit typed,
                              input fifo_result_t typed_res);
    fifo_result_t model_res;
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    @(negedge clk_i);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{IN_PAD_W{1'b0}}, val, q, op};
    do @(posedge clk_i); while (!s_tready);
    model_res = apply_fifo_op(op, q, val);
    pending_results.push_back(typed ? typed_res : model_res);
    case (op)
      MODE_PUSH: n_push++;
      MODE_READ: n_read++;
      MODE_POP:  n_pop++;
      default:   n_nop++;
    endcase
  endtask

  // Mostly random words, sometimes the extremes of the signed range
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Result side: random stall before each result
  initial begin
    int gap;
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      gap = calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    fifo_result_t want;
    logic [VAL_W-1:0]  got_front;
    logic [STAT_W-1:0] got_stat;
    if (rst_ni && m_tvalid && m_tready) begin
      got_front = m_tdata[VAL_W-1:0];
      got_stat  = m_tdata[OUT_STAT_LSB +: STAT_W];
      n_results++;
      if (got_stat == ST_FULL)  n_full++;
      if (got_stat == ST_EMPTY) n_empty++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: front_value %h status %0d", got_front, got_stat);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got_front !== want.front) begin
          $error("front_value: expected %h, actual %h", want.front, got_front);
          errors++;
        end
        if (got_stat !== want.stat) begin
          $error("status: expected %0d, actual %0d", want.stat, got_stat);
          errors++;
        end
      end
    end
  end

  // Hard stop in case the handshake hangs
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Reset, directed table, random bursts, drain
  initial begin
    fifo_result_t typed_res;
    fifo_result_t none_res;
    int n_real, burst_len, style, pick, focus_a, focus_b;
    bit focused;
    logic [MODE_W-1:0] op;
    logic [QIN_W-1:0]  q;

    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    calm     = 1'b0;
    errors   = 0;
    none_res = '{front: '0, stat: ST_DONE};
    for (int i = 0; i < QUEUES; i++) begin
      ring_head[i]  = '0;
      ring_count[i] = '0;
    end

    // Empty-queue cases, signed extremes, fill to full, wrap the ring, drain
    dir_tab[0]  = '{MODE_READ, 4'd0,  32'h0000_0000, 1,  1'b1, 32'h0000_0000, ST_EMPTY};
    dir_tab[1]  = '{MODE_POP,  4'd0,  32'hFFFF_FFFF, 1,  1'b1, 32'h0000_0000, ST_EMPTY};
    dir_tab[2]  = '{MODE_NOP,  4'd0,  32'hFFFF_FFFF, 1,  1'b1, 32'h0000_0000, ST_DONE};
    dir_tab[3]  = '{MODE_PUSH, 4'd15, 32'h8000_0000, 1,  1'b1, 32'h0000_0000, ST_DONE};
    dir_tab[4]  = '{MODE_PUSH, 4'd15, 32'h7FFF_FFFF, 1,  1'b1, 32'h0000_0000, ST_DONE};
    dir_tab[5]  = '{MODE_READ, 4'd15, 32'h0000_0000, 1,  1'b1, 32'h8000_0000, ST_DONE};
    dir_tab[6]  = '{MODE_POP,  4'd15, 32'h0000_0000, 1,  1'b1, 32'h0000_0000, ST_DONE};
    dir_tab[7]  = '{MODE_READ, 4'd15, 32'h0000_0000, 1,  1'b1, 32'h7FFF_FFFF, ST_DONE};
    dir_tab[8]  = '{MODE_POP,  4'd15, 32'h0000_0000, 1,  1'b1, 32'h0000_0000, ST_DONE};
    dir_tab[9]  = '{MODE_READ, 4'd15, 32'h0000_0000, 1,  1'b1, 32'h0000_0000, ST_EMPTY};
    dir_tab[10] = '{MODE_PUSH, 4'd3,  32'h0000_0000, 64, 1'b0, 32'h0000_0000, ST_DONE};
    dir_tab[11] = '{MODE_PUSH, 4'd3,  32'h1234_5678, 1,  1'b1, 32'h0000_0000, ST_FULL};
    dir_tab[12] = '{MODE_READ, 4'd3,  32'h0000_0000, 1,  1'b1, 32'h0000_0000, ST_DONE};
    dir_tab[13] = '{MODE_POP,  4'd3,  32'h0000_0000, 10, 1'b0, 32'h0000_0000, ST_DONE};
    dir_tab[14] = '{MODE_PUSH, 4'd3,  32'hA5A5_0000, 10, 1'b0, 32'h0000_0000, ST_DONE};
    dir_tab[15] = '{MODE_PUSH, 4'd3,  32'hFFFF_FFFF, 1,  1'b1, 32'h0000_0000, ST_FULL};
    dir_tab[16] = '{MODE_READ, 4'd3,  32'h0000_0000, 1,  1'b0, 32'h0000_0000, ST_DONE};
    dir_tab[17] = '{MODE_POP,  4'd3,  32'h0000_0000, 64, 1'b0, 32'h0000_0000, ST_DONE};
    dir_tab[18] = '{MODE_READ, 4'd3,  32'h0000_0000, 1,  1'b1, 32'h0000_0000, ST_EMPTY};
    dir_tab[19] = '{MODE_POP,  4'd3,  32'h0000_0000, 1,  1'b1, 32'h0000_0000, ST_EMPTY};
    dir_tab[20] = '{MODE_NOP,  4'd9,  32'h7FFF_FFFF, 1,  1'b1, 32'h0000_0000, ST_DONE};
    dir_tab[21] = '{MODE_PUSH, 4'd6,  32'hFFFF_FFFF, 1,  1'b1, 32'h0000_0000, ST_DONE};
    dir_tab[22] = '{MODE_READ, 4'd6,  32'h0000_0000, 1,  1'b1, 32'hFFFF_FFFF, ST_DONE};

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the table; repeated rows step the value so each slot holds a distinct word
    foreach (dir_tab[i]) begin
      typed_res = '{front: dir_tab[i].front, stat: dir_tab[i].stat};
      for (int r = 0; r < dir_tab[i].reps; r++)
        send_request(dir_tab[i].op, dir_tab[i].q, dir_tab[i].val + r, dir_tab[i].typed,
                     typed_res);
    end

    // Random bursts: fill-heavy, balanced, drain-heavy or noise, often aimed at one or two queues
    n_real = 0;
    while (n_real < REQ_TARGET) begin
      burst_len = $urandom_range(30, 120);
      style     = $urandom_range(0, 3);
      focused   = ($urandom_range(0, 2) != 0);
      focus_a   = $urandom_range(0, QUEUES - 1);
      focus_b   = $urandom_range(0, QUEUES - 1);
      calm      = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < burst_len && n_real < REQ_TARGET; k++) begin
        pick = $urandom_range(0, 99);
        case (style)
          0:       op = (pick < 75) ? MODE_PUSH : (pick < 87) ? MODE_READ :
                        (pick < 97) ? MODE_POP : MODE_NOP;
          1:       op = (pick < 45) ? MODE_PUSH : (pick < 65) ? MODE_READ :
                        (pick < 97) ? MODE_POP : MODE_NOP;
          2:       op = (pick < 20) ? MODE_PUSH : (pick < 40) ? MODE_READ :
                        (pick < 97) ? MODE_POP : MODE_NOP;
          default: op = MODE_W'($urandom_range(0, 3));
        endcase
        if (focused) q = QIN_W'(($urandom_range(0, 3) == 0) ? focus_b : focus_a);
        else q = QIN_W'($urandom_range(0, QUEUES - 1));
        send_request(op, q, pick_value(), 1'b0, none_res);
        if (op != MODE_NOP) n_real++;
      end
    end

    // Release the request side and let every outstanding result arrive
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    calm = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d pushes, %0d front reads, %0d pops, %0d unused-code requests",
             n_push, n_read, n_pop, n_nop);
    $display("Checked %0d results: %0d full-queue drops, %0d empty-queue answers",
             n_results, n_full, n_empty);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
